[rtl/csvft_pkg.sv]
package csvft_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic       field_end;
        logic       record_end;
        logic       syntax_error;
    } t_result;

    localparam t_result RESULT_NONE = '{
        char_valid: 1'b0, char_out: 8'h00, field_end: 1'b0,
        record_end: 1'b0, syntax_error: 1'b0
    };

endpackage

[rtl/csv_field_tokenizer_unit.sv]
// streaming csv field tokenizer, one text byte per word
// input channel: i_valid / o_stall with i_text_byte; a word is taken on a
//   rising edge with i_valid high and o_stall low
// output channel: o_valid / i_stall with o_char_valid, o_char_out,
//   o_field_end, o_record_end, o_syntax_error; taken with o_valid high and
//   i_stall low
// each byte gives one result word or none: a content byte, a field end
//   (with record end on lf) or a syntax error; cr outside quotes, nul,
//   opening and closing quotes and discarded bytes give no word
// path: a taken byte sits in the input register, then goes through parse
//   logic into the output register, where its result word is presented
// throughput: 1 byte per cycle unless stalled, set by the phase update
// reset (synchronous, i_rst_n low): both registers empty, parser back at
//   the start of a line
// when the receiver stalls, the result word holds and the pipeline freezes;
//   the input register takes one more byte before o_stall rises only if empty
module csv_field_tokenizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_char_valid,
    output logic [7:0] o_char_out,
    output logic       o_field_end,
    output logic       o_record_end,
    output logic       o_syntax_error
);
    import csvft_pkg::*;

    logic       advance;
    logic       word_valid;
    logic [7:0] word;
    logic       step;
    logic       has_result;
    t_result    result;
    t_result    out_result;

    csvft_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_text_byte  (i_text_byte),
        .i_advance    (advance),
        .o_stall      (o_stall),
        .o_word_valid (word_valid),
        .o_word       (word)
    );

    assign step = word_valid && advance;

    csvft_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (word),
        .o_has_result (has_result),
        .o_result     (result)
    );

    csvft_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (word_valid),
        .i_has_result (has_result),
        .i_result     (result),
        .i_stall      (i_stall),
        .o_advance    (advance),
        .o_valid      (o_valid),
        .o_result     (out_result)
    );

    assign o_char_valid   = out_result.char_valid;
    assign o_char_out     = out_result.char_out;
    assign o_field_end    = out_result.field_end;
    assign o_record_end   = out_result.record_end;
    assign o_syntax_error = out_result.syntax_error;

`ifndef ASSERT_OFF
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_syntax_error |-> !o_char_valid && !o_field_end && !o_record_end)
        else $error("syntax error word carries other marks");

    a_rec_has_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_end |-> o_field_end && !o_char_valid)
        else $error("record end without field end");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_char_valid |-> o_char_out == 8'h00)
        else $error("char_out nonzero on a mark word");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");
`endif
endmodule

[rtl/csvft_in_stage.sv]
module csvft_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_text_byte,
    input  logic       i_advance,
    output logic       o_stall,
    output logic       o_word_valid,
    output logic [7:0] o_word
);
    logic       r_valid;
    logic [7:0] r_byte;

    // slot frees when the parse stage takes the word
    assign o_stall = r_valid && !i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_byte <= i_text_byte;
        end
    end

    assign o_word_valid = r_valid;
    assign o_word       = r_byte;
endmodule

[rtl/csvft_parser.sv]
module csvft_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output logic                o_has_result,
    output csvft_pkg::t_result  o_result
);
    import csvft_pkg::*;

    typedef enum logic [2:0] {
        PH_LINE_START = 3'd0,
        PH_UNQUOTED   = 3'd1,
        PH_QUOTED     = 3'd2,
        PH_AFTER_SEP  = 3'd3,
        PH_QUOTE_SEEN = 3'd4,
        PH_DISCARD    = 3'd5
    } t_phase;

    t_phase  r_phase;
    t_phase  n_phase;
    logic    has;
    t_result res;
    t_result content;
    t_result fend;
    t_result rend;
    t_result serr;

    always_comb begin
        content            = RESULT_NONE;
        content.char_valid = 1'b1;
        content.char_out   = i_byte;
        fend               = RESULT_NONE;
        fend.field_end     = 1'b1;
        rend               = fend;
        rend.record_end    = 1'b1;
        serr               = RESULT_NONE;
        serr.syntax_error  = 1'b1;

        n_phase = r_phase;
        has     = 1'b0;
        res     = RESULT_NONE;

        // terminator byte is never data, ignored everywhere
        if (i_byte != CH_NUL) begin
            unique case (r_phase)
                PH_LINE_START, PH_AFTER_SEP: begin
                    priority if (i_byte == CH_QUOTE) begin
                        n_phase = PH_QUOTED;
                    end else if (i_byte == CH_CR) begin
                        n_phase = r_phase;
                    end else if (i_byte == CH_COMMA) begin
                        n_phase = PH_AFTER_SEP;
                        has     = 1'b1;
                        res     = fend;
                    end else if (i_byte == CH_LF) begin
                        n_phase = PH_LINE_START;
                        has     = 1'b1;
                        // empty line is an error, lf after comma ends an empty field
                        res     = (r_phase == PH_LINE_START) ? serr : rend;
                    end else begin
                        n_phase = PH_UNQUOTED;
                        has     = 1'b1;
                        res     = content;
                    end
                end
                PH_UNQUOTED: begin
                    priority if (i_byte == CH_CR) begin
                        n_phase = r_phase;
                    end else if (i_byte == CH_COMMA) begin
                        n_phase = PH_AFTER_SEP;
                        has     = 1'b1;
                        res     = fend;
                    end else if (i_byte == CH_LF) begin
                        n_phase = PH_LINE_START;
                        has     = 1'b1;
                        res     = rend;
                    end else begin
                        has = 1'b1;
                        res = content;
                    end
                end
                PH_QUOTED: begin
                    if (i_byte == CH_QUOTE) begin
                        n_phase = PH_QUOTE_SEEN;
                    end else begin
                        has = 1'b1;
                        res = content;
                    end
                end
                PH_QUOTE_SEEN: begin
                    priority if (i_byte == CH_CR) begin
                        n_phase = r_phase;
                    end else if (i_byte == CH_QUOTE) begin
                        // doubled quote is one literal quote
                        n_phase = PH_QUOTED;
                        has     = 1'b1;
                        res     = content;
                    end else if (i_byte == CH_COMMA) begin
                        n_phase = PH_AFTER_SEP;
                        has     = 1'b1;
                        res     = fend;
                    end else if (i_byte == CH_LF) begin
                        n_phase = PH_LINE_START;
                        has     = 1'b1;
                        res     = rend;
                    end else begin
                        n_phase = PH_DISCARD;
                        has     = 1'b1;
                        res     = serr;
                    end
                end
                default: begin
                    // discarding, unused codes too
                    if (i_byte == CH_LF) begin
                        n_phase = PH_LINE_START;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LINE_START;
        end else if (i_step) begin
            r_phase <= n_phase;
        end
    end

    assign o_has_result = has;
    assign o_result     = res;
endmodule

[rtl/csvft_out_stage.sv]
module csvft_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_has_result,
    input  csvft_pkg::t_result  i_result,
    input  logic                i_stall,
    output logic                o_advance,
    output logic                o_valid,
    output csvft_pkg::t_result  o_result
);
    import csvft_pkg::*;

    logic    r_valid;
    t_result r_result;

    // register is free when empty or being taken this cycle
    assign o_advance = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load && i_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

[bench/tb_csv_field_tokenizer_unit.sv]
module tb_csv_field_tokenizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import csvft_pkg::*;

    localparam int TAIL_LEN     = 80;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int TEXT_LEN     = 530;

    typedef enum logic [2:0] {
        P_LINE_START = 3'd0,
        P_UNQUOTED   = 3'd1,
        P_QUOTED     = 3'd2,
        P_AFTER_SEP  = 3'd3,
        P_QUOTE_SEEN = 3'd4,
        P_DISCARD    = 3'd5
    } t_phase;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_text_byte = 8'h00;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_char_valid;
    logic [7:0] o_char_out;
    logic       o_field_end;
    logic       o_record_end;
    logic       o_syntax_error;

    logic [7:0] text_q [$];
    t_result    expected_words [$];
    t_phase     tok_phase = P_LINE_START;
    logic [7:0] directed_text [27];

    int bytes_total = 0;
    int bytes_taken = 0;
    int fail_count = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;
    int src_gap = 0;
    int src_pct = 0;
    int snk_gap = 0;
    int snk_pct = 0;
    logic [5:0] src_cycle = '0;
    logic [5:0] snk_cycle = '0;

    csv_field_tokenizer_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_text_byte    (i_text_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_char_valid   (o_char_valid),
        .o_char_out     (o_char_out),
        .o_field_end    (o_field_end),
        .o_record_end   (o_record_end),
        .o_syntax_error (o_syntax_error)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    function automatic string word_str(input t_result w);
        return $sformatf("cv=%0b ch=%02h fe=%0b re=%0b se=%0b", w.char_valid, w.char_out,
                         w.field_end, w.record_end, w.syntax_error);
    endfunction

    task automatic add_text(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    task automatic add_expected(input t_result w);
        expected_words.insert(expected_words.size(), w);
    endtask

    // one text byte through the parser; queues the word it yields, if any
    task automatic tokenize_byte(input logic [7:0] b);
        t_result w;
        logic    emit;
        w = RESULT_NONE;
        emit = 1'b0;
        if (b != CH_NUL) begin
            case (tok_phase)
                P_LINE_START, P_AFTER_SEP: begin
                    if (b == CH_QUOTE) begin
                        tok_phase = P_QUOTED;
                    end else if (b == CH_COMMA) begin
                        tok_phase = P_AFTER_SEP;
                        w.field_end = 1'b1;
                        emit = 1'b1;
                    end else if (b == CH_LF) begin
                        // lf at line start is an empty line
                        if (tok_phase == P_LINE_START) begin
                            w.syntax_error = 1'b1;
                        end else begin
                            w.field_end = 1'b1;
                            w.record_end = 1'b1;
                        end
                        tok_phase = P_LINE_START;
                        emit = 1'b1;
                    end else if (b != CH_CR) begin
                        tok_phase = P_UNQUOTED;
                        w.char_valid = 1'b1;
                        w.char_out = b;
                        emit = 1'b1;
                    end
                end
                P_UNQUOTED: begin
                    if (b == CH_COMMA) begin
                        tok_phase = P_AFTER_SEP;
                        w.field_end = 1'b1;
                        emit = 1'b1;
                    end else if (b == CH_LF) begin
                        tok_phase = P_LINE_START;
                        w.field_end = 1'b1;
                        w.record_end = 1'b1;
                        emit = 1'b1;
                    end else if (b != CH_CR) begin
                        w.char_valid = 1'b1;
                        w.char_out = b;
                        emit = 1'b1;
                    end
                end
                P_QUOTED: begin
                    if (b == CH_QUOTE) begin
                        tok_phase = P_QUOTE_SEEN;
                    end else begin
                        w.char_valid = 1'b1;
                        w.char_out = b;
                        emit = 1'b1;
                    end
                end
                P_QUOTE_SEEN: begin
                    if (b == CH_QUOTE) begin
                        tok_phase = P_QUOTED;
                        w.char_valid = 1'b1;
                        w.char_out = CH_QUOTE;
                        emit = 1'b1;
                    end else if (b == CH_COMMA) begin
                        tok_phase = P_AFTER_SEP;
                        w.field_end = 1'b1;
                        emit = 1'b1;
                    end else if (b == CH_LF) begin
                        tok_phase = P_LINE_START;
                        w.field_end = 1'b1;
                        w.record_end = 1'b1;
                        emit = 1'b1;
                    end else if (b != CH_CR) begin
                        // stray byte after the closing quote
                        tok_phase = P_DISCARD;
                        w.syntax_error = 1'b1;
                        emit = 1'b1;
                    end
                end
                default: begin
                    if (b == CH_LF) tok_phase = P_LINE_START;
                end
            endcase
        end
        if (emit) add_expected(w);
    endtask

    task automatic check_word(input t_result got);
        t_result want;
        if (expected_words.size() == 0) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected word: %s", word_str(got));
        end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("word mismatch: expected %s, actual %s", word_str(want),
                             word_str(got));
                end
            end
        end
    endtask

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_text_byte <= 8'h00;
            src_gap <= 0;
            tok_phase = P_LINE_START;
        end else begin
            if (i_valid && !o_stall) begin
                tokenize_byte(i_text_byte);
                bytes_taken <= bytes_taken + 1;
            end
            src_cycle <= src_cycle + 1'b1;
            if (src_cycle == '0) src_pct <= pick_idle_pct();
            if (i_valid && o_stall) begin
                // hold the stalled word
            end else if (src_gap != 0) begin
                src_gap <= src_gap - 1;
                i_valid <= 1'b0;
            end else if (text_q.size() == 0) begin
                i_valid <= 1'b0;
            end else if (text_q.size() > TAIL_LEN && $urandom_range(0, 99) < src_pct) begin
                src_gap <= $urandom_range(0, 7);
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_text_byte <= text_q.pop_front();
            end
        end
    end

    // result side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            snk_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                check_word({o_char_valid, o_char_out, o_field_end, o_record_end,
                            o_syntax_error});
            end
            snk_cycle <= snk_cycle + 1'b1;
            if (snk_cycle == '0) snk_pct <= pick_idle_pct();
            if (snk_gap != 0) begin
                snk_gap <= snk_gap - 1;
                i_stall <= 1'b1;
            end else if (text_q.size() > TAIL_LEN && $urandom_range(0, 99) < snk_pct) begin
                snk_gap <= $urandom_range(0, 7);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[csv_field_tokenizer_unit] ERROR");
                $finish;
            end
        end
    end

    initial begin
        int         roll;
        int         nf;
        int         flen;
        int         kind;
        logic [7:0] c;

        // empty line, empty fields, extremes, quoted specials, stray after quote
        directed_text = '{
            CH_LF, CH_COMMA, CH_COMMA, CH_LF,
            8'hFF, CH_NUL, CH_CR, 8'h01, CH_QUOTE, CH_COMMA,
            CH_QUOTE, CH_COMMA, CH_CR, CH_LF, CH_QUOTE, CH_QUOTE, CH_NUL, CH_QUOTE,
            CH_CR, CH_LF,
            CH_QUOTE, 8'h61, CH_QUOTE, 8'h62, CH_COMMA, CH_QUOTE, CH_LF
        };
        foreach (directed_text[k]) add_text(directed_text[k]);

        while (text_q.size() < TEXT_LEN) begin
            roll = $urandom_range(0, 99);
            if (roll < 14) begin
                // junk line: specials and random bytes
                flen = $urandom_range(0, 8);
                for (int k = 0; k < flen; k++) begin
                    case ($urandom_range(0, 9))
                        0: c = CH_NUL;
                        1: c = CH_QUOTE;
                        2: c = CH_COMMA;
                        3: c = CH_CR;
                        4: c = CH_LF;
                        default: c = 8'($urandom_range(0, 255));
                    endcase
                    add_text(c);
                end
                add_text(CH_LF);
            end else begin
                nf = $urandom_range(1, 4);
                for (int f = 0; f < nf; f++) begin
                    if (f != 0) add_text(CH_COMMA);
                    kind = $urandom_range(0, 3);
                    if (kind == 3) begin
                        add_text(CH_QUOTE);
                        flen = $urandom_range(0, 6);
                        for (int k = 0; k < flen; k++) begin
                            c = 8'($urandom_range(0, 255));
                            add_text(c);
                            if (c == CH_QUOTE) add_text(CH_QUOTE);
                        end
                        add_text(CH_QUOTE);
                        if ($urandom_range(0, 7) == 0) add_text(CH_CR);
                        if ($urandom_range(0, 11) == 0) add_text(8'($urandom_range(1, 255)));
                    end else if (kind != 0) begin
                        flen = $urandom_range(1, 6);
                        for (int k = 0; k < flen; k++) begin
                            c = 8'($urandom_range(1, 255));
                            if (c == CH_COMMA || c == CH_LF) c = 8'h5F;
                            if (k == 0 && c == CH_QUOTE) c = 8'h27;
                            add_text(c);
                        end
                    end
                end
                if ($urandom_range(0, 3) == 0) add_text(CH_CR);
                add_text(CH_LF);
            end
        end
        bytes_total = text_q.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample on the falling edge so every update of the step has landed
        while (bytes_taken != bytes_total) @(negedge i_clk);
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("[csv_field_tokenizer_unit] OK");
        end else begin
            $display("[csv_field_tokenizer_unit] ERROR");
        end
        $finish;
    end

endmodule
